// File: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and codes of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int PAGE_W    = 14;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int CNT_OUT_W = 16;
    localparam int CFG_W     = 15;
    localparam int WIDE_W    = 17;

    localparam logic [REQ_W-1:0] REQ_INIT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INC   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEC   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [PAGE_W-1:0] page;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]    page_res;
        logic [CNT_OUT_W-1:0] ref_count;
        logic [STATUS_W-1:0]  status;
    } res_t;

endpackage

// File: rtl/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_allocator
// Physical page frame allocator with per-page reference counts and a LIFO
// free stack, both held in synchronous RAMs.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   request  | req_valid/req_ready  | req  (req_type, page)
//   result   | res_valid/res_ready  | res  (page_res, ref_count, status)
//   config   | APB psel/penable     | first_free_page, total_pages
//
// Free, increment and decrement: count RAM read, then update.
// Allocate: stack RAM read, count RAM read, update; empty stack: update only.
// Init sweeps the count RAM one page a cycle.
// After reset a clearing pass over every count RAM page runs before req_ready rises.
// A result waiting in the output register stalls the update step only.
// ----------------------------------------------------------------------------
module page_frame_allocator #(
    parameter int NUM_PAGES  = 16384,
    parameter int COUNT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pfa_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_ready,
    output pfa_pkg::res_t res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    import pfa_pkg::*;

    localparam int AW = $clog2(NUM_PAGES);
    localparam int TW = $clog2(NUM_PAGES + 1);
    localparam int CB = COUNT_BITS;

    localparam logic REG_FFP   = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_SWEEP,
        S_EXEC
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [TW-1:0]     top_reg, top_next;
    logic [REQ_W-1:0]  op_reg, op_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              pg_ok_reg, pg_ok_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg, res_next;
    logic [CFG_W-1:0]  ffp_reg, ffp_next;
    logic [CFG_W-1:0]  total_reg, total_next;

    logic              cnt_we, cnt_re;
    logic [AW-1:0]     cnt_waddr, cnt_raddr;
    logic [CB:0]       cnt_wdata, cnt_rdata;
    logic              stack_we, stack_re;
    logic [AW-1:0]     stack_waddr, stack_raddr, stack_wdata, stack_rdata;

    logic [CB-1:0]     cur_cnt;
    logic              cur_mark;
    logic [TW-1:0]     top_dec;
    logic [AW-1:0]     page_idx;
    logic              push_ok;
    logic              slot_free;
    logic              cfg_write;
    logic [WIDE_W-1:0] limit;
    logic              sweep_below, sweep_in_lim, sweep_last;

    pfa_ram #(.WIDTH(CB + 1), .DEPTH(NUM_PAGES)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    pfa_ram #(.WIDTH(AW), .DEPTH(NUM_PAGES)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    assign cur_cnt   = cnt_rdata[CB-1:0];
    assign cur_mark  = cnt_rdata[CB];
    assign top_dec   = top_reg - TW'(1);
    assign page_idx  = AW'(page_reg);
    assign push_ok   = !cur_mark && (top_reg < TW'(NUM_PAGES));
    assign slot_free = !out_valid_reg || res_ready;

    assign limit = (WIDE_W'(total_reg) > WIDE_W'(NUM_PAGES)) ?
                   WIDE_W'(NUM_PAGES) : WIDE_W'(total_reg);
    assign sweep_below  = WIDE_W'(idx_reg) < WIDE_W'(ffp_reg);
    assign sweep_in_lim = WIDE_W'(idx_reg) < limit;
    assign sweep_last   = idx_reg == AW'(NUM_PAGES - 1);

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_FFP:   prdata = 32'(ffp_reg);
            REG_TOTAL: prdata = 32'(total_reg);
            default:   prdata = 32'(ffp_reg);
        endcase
    end

    always_comb
    begin
        ffp_next   = ffp_reg;
        total_next = total_reg;
        if (cfg_write)
        begin
            if (paddr[2] == REG_TOTAL)
            begin
                total_next = pwdata[CFG_W-1:0];
            end
            else
            begin
                ffp_next = pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        top_next       = top_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        pg_ok_next     = pg_ok_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !res_ready;

        cnt_we      = 1'b0;
        cnt_waddr   = page_idx;
        cnt_wdata   = cnt_rdata;
        cnt_re      = 1'b0;
        cnt_raddr   = AW'(req.page);
        stack_we    = 1'b0;
        stack_waddr = top_reg[AW-1:0];
        stack_wdata = page_idx;
        stack_re    = 1'b0;
        stack_raddr = top_dec[AW-1:0];

        req_ready = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = idx_reg;
                cnt_wdata = '0;
                idx_next  = idx_reg + AW'(1);
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next    = req.req_type;
                    page_next  = req.page;
                    pg_ok_next = WIDE_W'(req.page) < WIDE_W'(NUM_PAGES);
                    state_next = S_EXEC;
                    unique case (req.req_type)
                        REQ_INIT:
                        begin
                            top_next   = '0;
                            idx_next   = '0;
                            state_next = S_SWEEP;
                        end
                        REQ_ALLOC:
                        begin
                            if (top_reg != '0)
                            begin
                                stack_re   = 1'b1;
                                state_next = S_ALLOC;
                            end
                        end
                        REQ_FREE, REQ_INC, REQ_DEC:
                        begin
                            cnt_re = pg_ok_next;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                cnt_re     = 1'b1;
                cnt_raddr  = stack_rdata;
                state_next = S_EXEC;
            end

            S_SWEEP:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = idx_reg;
                if (sweep_below)
                begin
                    cnt_wdata = {1'b0, CB'(1)};
                end
                else
                begin
                    cnt_wdata = {sweep_in_lim, CB'(0)};
                end
                stack_wdata = idx_reg;
                if (!sweep_below && sweep_in_lim)
                begin
                    stack_we = 1'b1;
                    top_next = top_reg + TW'(1);
                end
                idx_next = idx_reg + AW'(1);
                if (sweep_last)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                    res_next.page_res  = page_reg;
                    res_next.ref_count = '0;
                    res_next.status    = ST_OK;
                    unique case (op_reg)
                        REQ_INIT:
                        begin
                        end
                        REQ_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                res_next.page_res = '0;
                                res_next.status   = ST_NOMEM;
                            end
                            else
                            begin
                                top_next           = top_dec;
                                cnt_we             = 1'b1;
                                cnt_waddr          = stack_rdata;
                                cnt_wdata          = {1'b0, cur_cnt};
                                res_next.page_res  = PAGE_W'(stack_rdata);
                                res_next.ref_count = CNT_OUT_W'(cur_cnt);
                            end
                        end
                        REQ_FREE:
                        begin
                            if (pg_ok_reg)
                            begin
                                if (cur_cnt != '0)
                                begin
                                    res_next.status    = ST_BUSY;
                                    res_next.ref_count = CNT_OUT_W'(cur_cnt);
                                end
                                else if (push_ok)
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_wdata = {1'b1, CB'(0)};
                                    stack_we  = 1'b1;
                                    top_next  = top_reg + TW'(1);
                                end
                                else
                                begin
                                    res_next.status = ST_FREED;
                                end
                            end
                        end
                        REQ_INC:
                        begin
                            if (pg_ok_reg)
                            begin
                                if (&cur_cnt)
                                begin
                                    res_next.status    = ST_LIMIT;
                                    res_next.ref_count = CNT_OUT_W'(cur_cnt);
                                end
                                else
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_wdata = {cur_mark, cur_cnt + CB'(1)};
                                    res_next.ref_count =
                                        CNT_OUT_W'(cur_cnt + CB'(1));
                                end
                            end
                        end
                        REQ_DEC:
                        begin
                            if (pg_ok_reg)
                            begin
                                if (cur_cnt == '0)
                                begin
                                    res_next.status = ST_LIMIT;
                                end
                                else if (cur_cnt != CB'(1))
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_wdata = {cur_mark, cur_cnt - CB'(1)};
                                    res_next.ref_count =
                                        CNT_OUT_W'(cur_cnt - CB'(1));
                                end
                                else if (push_ok)
                                begin
                                    cnt_we    = 1'b1;
                                    cnt_wdata = {1'b1, CB'(0)};
                                    stack_we  = 1'b1;
                                    top_next  = top_reg + TW'(1);
                                end
                                else
                                begin
                                    cnt_we          = 1'b1;
                                    cnt_wdata       = {cur_mark, CB'(0)};
                                    res_next.status = ST_FREED;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            top_reg       <= '0;
            op_reg        <= REQ_INIT;
            page_reg      <= '0;
            pg_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
            ffp_reg       <= '0;
            total_reg     <= CFG_W'(16384);
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            top_reg       <= top_next;
            op_reg        <= op_next;
            page_reg      <= page_next;
            pg_ok_reg     <= pg_ok_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            ffp_reg       <= ffp_next;
            total_reg     <= total_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(NUM_PAGES))
        else $error("free stack pointer beyond depth");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!cnt_we && !stack_we))
        else $error("RAM write while idle");

    a_res_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> ($past(state_reg) == S_EXEC))
        else $error("result raised outside the update step");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("second request taken while one is in flight");

endmodule

// File: tb/sv/tb_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// tb_page_frame_allocator
// Self-checking bench for the page frame allocator. Requests go through a
// queue into a valid/ready driver. A predictor of the count table and free
// stack turns each accepted request into the result it should give. A monitor
// checks every result transfer against the oldest prediction. Phases change
// first_free_page and total_pages over the APB port while the block is idle.
// Random idling runs on both channels. A final mixed burst runs with no
// idling.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam int NUM_PAGES       = 16384;
    localparam int COUNT_BITS      = 16;
    localparam int REG_FIRST_FREE  = 0;
    localparam int REG_TOTAL_PAGES = 1;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_PHASES      = 7;
    localparam int TAIL_ITEMS      = 30;

    localparam logic [REQ_W-1:0] REQ_RSVD5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req       = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_t        res;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    bit [COUNT_BITS-1:0] page_counts [NUM_PAGES];
    bit [PAGE_W-1:0]     free_stack_pages [NUM_PAGES];
    bit                  page_on_stack [NUM_PAGES];
    int                  free_depth = 0;
    bit [CFG_W-1:0]      first_free_cfg = '0;
    bit [CFG_W-1:0]      total_pages_cfg = 15'd16384;

    req_t pending_reqs [$];
    res_t expected_results [$];
    res_t oldest_result;

    int idle_left   = 0;
    int stall_left  = 0;
    int error_count = 0;
    int cycle_count = 0;
    bit gaps_on     = 1'b1;

    logic [REQ_W-1:0] unused_kinds [3] = '{REQ_RSVD5, REQ_RSVD6, REQ_RSVD7};

    int phase_first [NUM_PHASES] = '{8, 0, 16384, 32767, 20, 16370, 3};
    int phase_total [NUM_PHASES] = '{40, 1, 16384, 32767, 10, 20000, 24};
    int phase_lo    [NUM_PHASES] = '{0, 0, 0, 16370, 0, 16360, 0};
    int phase_hi    [NUM_PHASES] = '{47, 6, 15, 16383, 27, 16383, 30};
    int phase_items [NUM_PHASES] = '{160, 60, 100, 80, 140, 160, 160};

    page_frame_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [STATUS_W-1:0] push_free_page(logic [PAGE_W-1:0] pg);
        if (page_on_stack[pg] || free_depth >= NUM_PAGES)
            return ST_FREED;
        free_stack_pages[free_depth] = pg;
        free_depth++;
        page_on_stack[pg] = 1'b1;
        return ST_OK;
    endfunction

    function automatic res_t allocator_result(req_t r);
        res_t                  r_out;
        int                    limit;
        logic [PAGE_W-1:0]     pg;
        logic [COUNT_BITS-1:0] c;
        r_out.page_res  = r.page;
        r_out.ref_count = '0;
        r_out.status    = ST_OK;
        c = page_counts[r.page];
        case (r.req_type)
            REQ_INIT:
            begin
                limit = (total_pages_cfg > NUM_PAGES) ? NUM_PAGES : int'(total_pages_cfg);
                free_depth = 0;
                for (int p = 0; p < NUM_PAGES; p++)
                begin
                    page_on_stack[p] = 1'b0;
                    if (p < first_free_cfg)
                        page_counts[p] = COUNT_BITS'(1);
                    else
                    begin
                        page_counts[p] = '0;
                        if (p < limit)
                            void'(push_free_page(p[PAGE_W-1:0]));
                    end
                end
            end
            REQ_ALLOC:
            begin
                if (free_depth == 0)
                begin
                    r_out.page_res = '0;
                    r_out.status   = ST_NOMEM;
                end
                else
                begin
                    free_depth--;
                    pg = free_stack_pages[free_depth];
                    page_on_stack[pg] = 1'b0;
                    r_out.page_res  = pg;
                    r_out.ref_count = page_counts[pg];
                end
            end
            REQ_FREE:
            begin
                if (c != 0)
                begin
                    r_out.status    = ST_BUSY;
                    r_out.ref_count = c;
                end
                else
                    r_out.status = push_free_page(r.page);
            end
            REQ_INC:
            begin
                if (c == {COUNT_BITS{1'b1}})
                begin
                    r_out.status    = ST_LIMIT;
                    r_out.ref_count = c;
                end
                else
                begin
                    page_counts[r.page] = c + 1'b1;
                    r_out.ref_count     = c + 1'b1;
                end
            end
            REQ_DEC:
            begin
                if (c == 0)
                    r_out.status = ST_LIMIT;
                else
                begin
                    page_counts[r.page] = c - 1'b1;
                    r_out.ref_count     = c - 1'b1;
                    if (c == 1)
                        r_out.status = push_free_page(r.page);
                end
            end
            default:
            begin
            end
        endcase
        return r_out;
    endfunction

    // request driver: hold payload until the transfer, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            idle_left <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                expected_results.push_back(allocator_result(req));
            if (!req_valid || req_ready)
            begin
                if (idle_left > 0)
                begin
                    idle_left <= idle_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    req_valid <= 1'b0;
                else if (gaps_on && $urandom_range(0, 9) == 0)
                begin
                    idle_left <= $urandom_range(0, 14);
                    req_valid <= 1'b0;
                end
                else
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // result monitor: check each transfer, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected result: page %0d count %0d status %0d",
                                 res.page_res, res.ref_count, res.status);
                    error_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (res.page_res !== oldest_result.page_res ||
                        res.ref_count !== oldest_result.ref_count ||
                        res.status !== oldest_result.status)
                    begin
                        if (error_count < MAX_REPORTS)
                            $display({"result mismatch: got page %0d count %0d status %0d,",
                                      " want page %0d count %0d status %0d"},
                                     res.page_res, res.ref_count, res.status,
                                     oldest_result.page_res, oldest_result.ref_count,
                                     oldest_result.status);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                res_ready  <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 14);
                res_ready  <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[page_frame_allocator] ERROR");
            $finish;
        end
    end

    task automatic queue_request(logic [REQ_W-1:0] kind, int pg);
        req_t item;
        item.req_type = kind;
        item.page     = pg[PAGE_W-1:0];
        pending_reqs.push_back(item);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(int index, logic [CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(index * 4);
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_FIRST_FREE)
            first_free_cfg = value;
        else
            total_pages_cfg = value;
    endtask

    initial
    begin
        req_t item;
        int   pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_request(REQ_ALLOC, 0);
        queue_request(REQ_FREE, 7);
        queue_request(REQ_ALLOC, 5);
        queue_request(REQ_INIT, 16383);
        queue_request(REQ_ALLOC, 0);
        queue_request(REQ_ALLOC, 0);
        queue_request(REQ_FREE, 16383);
        queue_request(REQ_FREE, 16383);
        queue_request(REQ_INC, 16383);
        queue_request(REQ_FREE, 16383);
        queue_request(REQ_DEC, 16383);
        queue_request(REQ_DEC, 16383);
        queue_request(REQ_INC, 16382);
        queue_request(REQ_INC, 16382);
        queue_request(REQ_DEC, 16382);
        queue_request(REQ_DEC, 16382);
        queue_request(REQ_ALLOC, 0);
        queue_request(REQ_ALLOC, 0);
        queue_request(REQ_ALLOC, 0);
        queue_request(REQ_RSVD5, 'h2AAA);
        queue_request(REQ_RSVD6, 'h1555);
        queue_request(REQ_RSVD7, 16383);
        queue_request(REQ_INC, 0);
        queue_request(REQ_DEC, 0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_register(REG_FIRST_FREE, CFG_W'(phase_first[ph]));
            write_register(REG_TOTAL_PAGES, CFG_W'(phase_total[ph]));
            queue_request(REQ_INIT, $urandom_range(0, NUM_PAGES - 1));
            if (phase_total[ph] == 1)
            begin
                queue_request(REQ_ALLOC, 0);
                queue_request(REQ_ALLOC, 0);
                queue_request(REQ_FREE, 0);
                queue_request(REQ_FREE, 0);
            end
            for (int k = 0; k < phase_items[ph]; k++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0)
                    item.page = PAGE_W'($urandom);
                else
                    item.page = PAGE_W'($urandom_range(phase_lo[ph], phase_hi[ph]));
                if (pick < 2)
                    item.req_type = unused_kinds[$urandom_range(0, 2)];
                else if (pick < 30)
                    item.req_type = REQ_ALLOC;
                else if (pick < 50)
                    item.req_type = REQ_FREE;
                else if (pick < 75)
                    item.req_type = REQ_INC;
                else
                    item.req_type = REQ_DEC;
                pending_reqs.push_back(item);
            end
            wait_idle();
        end

        // run a short mixed burst on low pages 0 to 7, no idling
        gaps_on = 1'b0;
        queue_request(REQ_INIT, 0);
        for (int k = 0; k < TAIL_ITEMS; k++)
        begin
            pick = $urandom_range(0, 3);
            item.page = PAGE_W'($urandom_range(0, 7));
            if (pick == 0)
                item.req_type = REQ_ALLOC;
            else if (pick == 1)
                item.req_type = REQ_FREE;
            else if (pick == 2)
                item.req_type = REQ_INC;
            else
                item.req_type = REQ_DEC;
            pending_reqs.push_back(item);
        end
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[page_frame_allocator] OK");
        else
            $display("[page_frame_allocator] ERROR");
        $finish;
    end

endmodule
